[src/tds_pkg.sv]
// Shared widths, register indexes and cell control type for the triangle depth sorter.
package tds_pkg;

    localparam int MAX_FACES_DEF  = 64;
    localparam int COORD_BITS_DEF = 24;
    localparam int FIELD_BITS     = 24;
    localparam int TAG_BITS       = 16;
    localparam int KEY_BITS       = 53;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_CAMERA_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAMERA_Z = 2'd2;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_cell_ctrl;

endpackage

[src/tds_depth_calc.sv]
// Three-stage pipeline that turns a triangle and the camera position into its depth key.
module tds_depth_calc #(
    parameter int COORD_BITS = tds_pkg::COORD_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic [tds_pkg::TAG_BITS-1:0]              i_tag,
    input  logic                                      i_final,
    input  logic [2:0][tds_pkg::FIELD_BITS-1:0]       i_cam,
    input  logic [2:0][tds_pkg::FIELD_BITS-1:0]       i_v0,
    input  logic [2:0][tds_pkg::FIELD_BITS-1:0]       i_v1,
    input  logic [2:0][tds_pkg::FIELD_BITS-1:0]       i_v2,
    output logic                                      o_valid,
    output logic [tds_pkg::TAG_BITS-1:0]              o_tag,
    output logic                                      o_final,
    output logic [tds_pkg::KEY_BITS-1:0]              o_key
);

    localparam int DIFF_W = COORD_BITS + 3;
    localparam int MAG_W  = COORD_BITS + 2;
    localparam int SQ_W   = 2 * MAG_W;

    function automatic logic signed [DIFF_W-1:0] f_sext(
        input logic [tds_pkg::FIELD_BITS-1:0] raw
    );
        return {{(DIFF_W-COORD_BITS){raw[COORD_BITS-1]}}, raw[COORD_BITS-1:0]};
    endfunction

    logic signed [DIFF_W-1:0]       w_diff [3];
    logic [MAG_W-1:0]               n_mag  [3];
    logic [MAG_W-1:0]               r_mag  [3];
    logic [SQ_W-1:0]                r_sq   [3];
    logic [tds_pkg::KEY_BITS-1:0]   r_key;
    logic                           r_v1, r_v2, r_v3;
    logic                           r_fin1, r_fin2, r_fin3;
    logic [tds_pkg::TAG_BITS-1:0]   r_tag1, r_tag2, r_tag3;

    // Per axis: three times the camera minus the vertex sum, then its magnitude.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_diff[a] = f_sext(i_cam[a]) + (f_sext(i_cam[a]) <<< 1)
                      - (f_sext(i_v0[a]) + f_sext(i_v1[a]) + f_sext(i_v2[a]));
            n_mag[a]  = w_diff[a][DIFF_W-1] ? MAG_W'(-w_diff[a]) : MAG_W'(w_diff[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_mag[a] <= n_mag[a];
            r_sq[a]  <= r_mag[a] * r_mag[a];
        end
        r_key  <= tds_pkg::KEY_BITS'(r_sq[0]) + tds_pkg::KEY_BITS'(r_sq[1])
                + tds_pkg::KEY_BITS'(r_sq[2]);
        r_tag1 <= i_tag;
        r_tag2 <= r_tag1;
        r_tag3 <= r_tag2;
        r_fin1 <= i_final;
        r_fin2 <= r_fin1;
        r_fin3 <= r_fin2;
    end

    assign o_valid = r_v3;
    assign o_tag   = r_tag3;
    assign o_final = r_fin3;
    assign o_key   = r_key;

endmodule

[src/tds_sort_cell.sv]
// One cell of the sorted chain: holds a key and tag, shifts right on insert, left on drain.
module tds_sort_cell (
    input  logic                            i_clk,
    input  tds_pkg::t_cell_ctrl             i_ctrl,
    input  logic                            i_occupied,
    input  logic [tds_pkg::KEY_BITS-1:0]    i_new_key,
    input  logic [tds_pkg::TAG_BITS-1:0]    i_new_tag,
    input  logic                            i_prev_take,
    input  logic [tds_pkg::KEY_BITS-1:0]    i_prev_key,
    input  logic [tds_pkg::TAG_BITS-1:0]    i_prev_tag,
    input  logic [tds_pkg::KEY_BITS-1:0]    i_next_key,
    input  logic [tds_pkg::TAG_BITS-1:0]    i_next_tag,
    output logic                            o_take,
    output logic [tds_pkg::KEY_BITS-1:0]    o_key,
    output logic [tds_pkg::TAG_BITS-1:0]    o_tag
);

    logic [tds_pkg::KEY_BITS-1:0] r_key;
    logic [tds_pkg::TAG_BITS-1:0] r_tag;

    // A new key goes ahead of the first entry that is strictly nearer, so ties keep
    // arrival order.
    assign o_take = !i_occupied || (r_key < i_new_key);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (i_prev_take) begin
                r_key <= i_prev_key;
                r_tag <= i_prev_tag;
            end else if (o_take) begin
                r_key <= i_new_key;
                r_tag <= i_new_tag;
            end
        end else if (i_ctrl.shift_out) begin
            r_key <= i_next_key;
            r_tag <= i_next_tag;
        end
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

[src/triangle_depth_sort_unit.sv]
// Top level: camera registers, depth pipeline, sorting cell chain and drain control.
// A triangle's key enters the cell chain once it has passed the magnitude, square and key-sum registers.
// Throughput: one triangle per cycle while a set loads; after the final triangle the
// input stalls until the chain has drained, one sorted result per cycle as taken.
// Drain of n entries takes n result transfers, starting when the final triangle's key enters the chain.
// Reset clears the camera to zero, the pipeline, the entry count and the overflow flag.
module triangle_depth_sort_unit #(
    parameter int MAX_FACES  = tds_pkg::MAX_FACES_DEF,
    parameter int COORD_BITS = tds_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tds_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [tds_pkg::TAG_BITS-1:0]          i_face_tag,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_first_x,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_first_y,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_first_z,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_second_x,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_second_y,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_second_z,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_third_x,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_third_y,
    input  logic [tds_pkg::FIELD_BITS-1:0]        i_third_z,
    input  logic                                  i_final_face,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [tds_pkg::TAG_BITS-1:0]          o_sorted_tag,
    output logic [tds_pkg::KEY_BITS-1:0]          o_depth_key,
    output logic                                  o_overflowed,
    output logic                                  o_last_of_run
);

    localparam int CNT_W = $clog2(MAX_FACES + 1);

    logic [tds_pkg::FIELD_BITS-1:0] r_cam_x, r_cam_y, r_cam_z;
    logic [CNT_W-1:0]               r_count;
    logic                           r_overflow;
    logic                           r_draining;
    logic                           r_busy;

    logic                           w_pipe_valid;
    logic [tds_pkg::TAG_BITS-1:0]   w_pipe_tag;
    logic                           w_pipe_final;
    logic [tds_pkg::KEY_BITS-1:0]   w_pipe_key;
    logic                           w_has_room;
    tds_pkg::t_cell_ctrl            w_ctrl;

    logic                           w_take      [MAX_FACES];
    logic                           w_occ       [MAX_FACES];
    logic                           w_prev_take [MAX_FACES];
    logic [tds_pkg::KEY_BITS-1:0]   w_key       [MAX_FACES];
    logic [tds_pkg::TAG_BITS-1:0]   w_tag       [MAX_FACES];
    logic [tds_pkg::KEY_BITS-1:0]   w_prev_key  [MAX_FACES];
    logic [tds_pkg::TAG_BITS-1:0]   w_prev_tag  [MAX_FACES];
    logic [tds_pkg::KEY_BITS-1:0]   w_next_key  [MAX_FACES];
    logic [tds_pkg::TAG_BITS-1:0]   w_next_tag  [MAX_FACES];

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_busy;

    tds_depth_calc #(
        .COORD_BITS (COORD_BITS)
    ) u_depth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid && o_ready),
        .i_tag   (i_face_tag),
        .i_final (i_final_face),
        .i_cam   ({r_cam_z, r_cam_y, r_cam_x}),
        .i_v0    ({i_first_z, i_first_y, i_first_x}),
        .i_v1    ({i_second_z, i_second_y, i_second_x}),
        .i_v2    ({i_third_z, i_third_y, i_third_x}),
        .o_valid (w_pipe_valid),
        .o_tag   (w_pipe_tag),
        .o_final (w_pipe_final),
        .o_key   (w_pipe_key)
    );

    assign w_has_room       = r_count < CNT_W'(MAX_FACES);
    assign w_ctrl.insert    = w_pipe_valid && w_has_room;
    assign w_ctrl.shift_out = o_valid && i_ready;

    for (genvar gi = 0; gi < MAX_FACES; gi++) begin : g_cell
        assign w_occ[gi] = CNT_W'(gi) < r_count;

        if (gi == 0) begin : g_head
            assign w_prev_take[gi] = 1'b0;
            assign w_prev_key[gi]  = w_key[gi];
            assign w_prev_tag[gi]  = w_tag[gi];
        end else begin : g_body
            assign w_prev_take[gi] = w_take[gi-1];
            assign w_prev_key[gi]  = w_key[gi-1];
            assign w_prev_tag[gi]  = w_tag[gi-1];
        end

        if (gi == MAX_FACES - 1) begin : g_tail
            assign w_next_key[gi] = w_key[gi];
            assign w_next_tag[gi] = w_tag[gi];
        end else begin : g_link
            assign w_next_key[gi] = w_key[gi+1];
            assign w_next_tag[gi] = w_tag[gi+1];
        end

        tds_sort_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_occupied  (w_occ[gi]),
            .i_new_key   (w_pipe_key),
            .i_new_tag   (w_pipe_tag),
            .i_prev_take (w_prev_take[gi]),
            .i_prev_key  (w_prev_key[gi]),
            .i_prev_tag  (w_prev_tag[gi]),
            .i_next_key  (w_next_key[gi]),
            .i_next_tag  (w_next_tag[gi]),
            .o_take      (w_take[gi]),
            .o_key       (w_key[gi]),
            .o_tag       (w_tag[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x    <= '0;
            r_cam_y    <= '0;
            r_cam_z    <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_draining <= 1'b0;
            r_busy     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tds_pkg::REG_CAMERA_X: r_cam_x <= i_cfg_data;
                    tds_pkg::REG_CAMERA_Y: r_cam_y <= i_cfg_data;
                    tds_pkg::REG_CAMERA_Z: r_cam_z <= i_cfg_data;
                    default: ;
                endcase
            end

            // The input closes from the final triangle's transfer until the drain ends.
            if (i_valid && o_ready && i_final_face) begin
                r_busy <= 1'b1;
            end

            if (w_pipe_valid) begin
                if (w_has_room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
                if (w_pipe_final) begin
                    r_draining <= 1'b1;
                end
            end

            if (w_ctrl.shift_out) begin
                r_count <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    r_draining <= 1'b0;
                    r_busy     <= 1'b0;
                    r_overflow <= 1'b0;
                end
            end
        end
    end

    assign o_valid       = r_draining;
    assign o_sorted_tag  = w_tag[0];
    assign o_depth_key   = w_key[0];
    assign o_overflowed  = r_overflow;
    assign o_last_of_run = r_count == CNT_W'(1);

endmodule
